[hw/rtl/ofrb_pkg.sv]
// Shared types and constants for the output frame ring buffer.
package ofrb_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FRAME_W = 11;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned SIZE_W  = 10;

   localparam logic [BYTE_W-1:0] RING_SIZE_RESET = 8'd255;
   localparam logic [SIZE_W-1:0] MIN_SIZE        = 10'd2;
   localparam logic [SIZE_W-1:0] FULL_MARGIN     = 10'd3;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_POST  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [BYTE_W-1:0]    data_byte;
      logic [FRAME_W-1:0]   frame_in;
   } req_type;

   typedef struct packed {
      logic                 success;
      logic [FRAME_W-1:0]   read_value;
      logic [COUNT_W-1:0]   fill_count;
      logic                 full_flag;
      logic                 has_data;
   } rsp_type;

   typedef struct packed {
      logic                 success;
      logic                 use_byte;
      logic [FRAME_W-1:0]   frame_value;
      logic [COUNT_W-1:0]   fill_count;
      logic                 full_flag;
      logic                 has_data;
   } step_type;

endpackage

[hw/rtl/ofrb_mem.sv]
// Byte store of the ring: one write port, one registered read port.
module ofrb_mem
   import ofrb_pkg::*;
#(
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ofrb_ctrl.sv]
// Ring pointers, control frame slot, size register and per-request status.
module ofrb_ctrl
   import ofrb_pkg::*;
#(
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   input  logic              csr_write,
   input  logic [7:0]        csr_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   output step_type          step
);

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(DEPTH);

   logic [7:0]         ring_size_ff;
   logic [ADDR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   logic [SIZE_W-1:0]  size_raw;
   logic [SIZE_W-1:0]  eff_size;
   logic [SIZE_W-1:0]  wr_next_w;
   logic [SIZE_W-1:0]  rd_next_w;
   logic [ADDR_W-1:0]  wr_next;
   logic [ADDR_W-1:0]  rd_next;
   logic [SIZE_W-1:0]  count_w;

   assign size_raw = SIZE_W'(ring_size_ff);

   always_comb begin
      if (size_raw < MIN_SIZE) begin
         eff_size = MIN_SIZE;
      end else if (size_raw > MAX_SIZE) begin
         eff_size = MAX_SIZE;
      end else begin
         eff_size = size_raw;
      end
   end

   assign wr_next_w = SIZE_W'(wr_idx_ff) + SIZE_W'(1);
   assign rd_next_w = SIZE_W'(rd_idx_ff) + SIZE_W'(1);
   assign wr_next   = (wr_next_w >= eff_size) ? '0 : wr_next_w[ADDR_W-1:0];
   assign rd_next   = (rd_next_w >= eff_size) ? '0 : rd_next_w[ADDR_W-1:0];

   always_comb begin
      wr_idx_in        = wr_idx_ff;
      rd_idx_in        = rd_idx_ff;
      pend_in          = pend_ff;
      frame_in         = frame_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      step.success     = 1'b0;
      step.use_byte    = 1'b0;
      step.frame_value = '0;
      case (req.opcode)
         OP_PUSH: begin
            if (wr_next != rd_idx_ff) begin
               wr_en        = accept;
               wr_idx_in    = wr_next;
               step.success = 1'b1;
            end
         end
         OP_POP: begin
            if (wr_idx_ff != rd_idx_ff) begin
               rd_en         = accept;
               rd_idx_in     = rd_next;
               step.success  = 1'b1;
               step.use_byte = 1'b1;
            end else if (pend_ff) begin
               step.frame_value = frame_ff;
               pend_in          = 1'b0;
               frame_in         = '0;
               step.success     = 1'b1;
            end
         end
         OP_CLEAR: begin
            rd_idx_in = wr_idx_ff;
         end
         OP_POST: begin
            if (!pend_ff) begin
               pend_in      = 1'b1;
               frame_in     = req.frame_in;
               step.success = 1'b1;
            end
         end
         default: begin
            rd_idx_in = rd_idx_ff;
         end
      endcase
      if (wr_idx_in >= rd_idx_in) begin
         count_w = SIZE_W'(wr_idx_in) - SIZE_W'(rd_idx_in);
      end else begin
         count_w = SIZE_W'(wr_idx_in) + eff_size - SIZE_W'(rd_idx_in);
      end
      step.fill_count = count_w[COUNT_W-1:0];
      step.full_flag  = (eff_size <= count_w + FULL_MARGIN);
      step.has_data   = (count_w != '0) || pend_in;
   end

   assign wr_addr = wr_idx_ff;
   assign wr_data = req.data_byte;
   assign rd_addr = rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         frame_ff     <= '0;
      end else if (csr_write) begin
         ring_size_ff <= csr_data;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
      end else if (accept) begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
         frame_ff  <= frame_in;
      end
   end

endmodule

[hw/rtl/ofrb_out.sv]
// Status stage and result register with backpressure.
module ofrb_out
   import ofrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  step_type          step,
   input  logic [BYTE_W-1:0] mem_data,
   output logic              in_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload
);

   logic     stage_valid_ff;
   step_type stage_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;
   logic     move;

   assign move     = !rsp_valid_ff || rsp_ready;
   assign in_ready = !stage_valid_ff || move;

   always_comb begin
      rsp_in.success    = stage_ff.success;
      rsp_in.read_value = stage_ff.use_byte ? FRAME_W'(mem_data) : stage_ff.frame_value;
      rsp_in.fill_count = stage_ff.fill_count;
      rsp_in.full_flag  = stage_ff.full_flag;
      rsp_in.has_data   = stage_ff.has_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (in_ready) begin
            stage_valid_ff <= accept;
         end
         if (move) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= step;
      end
      if (move && stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/output_frame_ring_buffer.sv]
// Output frame ring buffer top level.
//
// Requests arrive on req_valid/req_ready with a req_type payload: push a byte,
// pop, clear the ring or post a control frame. Each request gives exactly one
// response on rsp_valid/rsp_ready with success, the popped byte or frame, the
// fill count and the full and data-available flags.
// The csr channel writes the ring size; a write also empties the ring and
// keeps any pending frame. It is ready in any cycle that accepts no request.
// Throughput is one request per cycle while the receiver keeps rsp_ready
// high: pointers and the frame slot update at the request edge, the byte
// store read is registered in the status stage and the result register
// follows it.
// Reset empties the ring, drops any pending frame and sets the size to 255.
// When the receiver stalls the result register holds, the status stage fills,
// and req_ready falls until rsp_ready returns.
module output_frame_ring_buffer
   import ofrb_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);

   logic              accept;
   logic              csr_write;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   step_type          step;

   assign accept    = req_valid && req_ready;
   assign csr_ready = !accept;
   assign csr_write = csr_valid && csr_ready;

   ofrb_ctrl #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .step      (step)
   );

   ofrb_mem #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ofrb_out u_out (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .step        (step),
      .mem_data    (rd_data),
      .in_ready    (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/ofrb_checker.sv]
// Port-level checks for the output frame ring buffer, bound to the top level.
module ofrb_checker
   import ofrb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fill_count != 8'd0 |-> rsp_payload.has_data)
      else $error("bytes held but data-available low");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.read_value != 11'd0 |-> rsp_payload.success)
      else $error("value returned by a failed request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fill_count >= 8'd253 |-> rsp_payload.full_flag)
      else $error("full flag low with ring nearly full");

endmodule

bind output_frame_ring_buffer ofrb_checker u_ofrb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
